### src/obb_pkg.sv
// Shared widths, stage records and helper functions of the oriented box overlap test.
package obb_pkg;

    localparam int POS_W      = 16;
    localparam int HALF_W     = 15;
    localparam int DIR_W      = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int DPROD_W    = 2 * DIR_W;
    localparam int DOT_W      = DPROD_W + 1;
    localparam int DOTMAG_W   = DPROD_W;
    localparam int CPROD_W    = DIFF_W + DIR_W;
    localparam int CSUM_W     = CPROD_W + 1;
    localparam int CMAG_W     = CPROD_W;
    localparam int EXT_W      = DOTMAG_W + HALF_W;
    localparam int DIST_SHIFT = 14;
    localparam int HALF_SHIFT = 28;
    localparam int DIST_W     = CMAG_W + DIST_SHIFT;
    localparam int CMP_W      = EXT_W + 2;

    typedef struct packed {
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic        [HALF_W-1:0] hw;
        logic        [HALF_W-1:0] hh;
        logic signed [DIR_W-1:0] c;
        logic signed [DIR_W-1:0] s;
    } t_box;

    typedef struct packed {
        logic        [HALF_W-1:0] ahw;
        logic        [HALF_W-1:0] ahh;
        logic        [HALF_W-1:0] bhw;
        logic        [HALF_W-1:0] bhh;
    } t_halves;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DPROD_W-1:0] pcc;
        logic signed [DPROD_W-1:0] pss;
        logic signed [DPROD_W-1:0] pcs;
        logic signed [DPROD_W-1:0] psc;
        logic signed [DIR_W-1:0]   ac;
        logic signed [DIR_W-1:0]   as;
        logic signed [DIR_W-1:0]   bc;
        logic signed [DIR_W-1:0]   bs;
        t_halves                   h;
    } t_s1;

    typedef struct packed {
        logic        [DOTMAG_W-1:0] pmag;
        logic        [DOTMAG_W-1:0] qmag;
        logic signed [CPROD_W-1:0]  daw0;
        logic signed [CPROD_W-1:0]  daw1;
        logic signed [CPROD_W-1:0]  dah0;
        logic signed [CPROD_W-1:0]  dah1;
        logic signed [CPROD_W-1:0]  dbw0;
        logic signed [CPROD_W-1:0]  dbw1;
        logic signed [CPROD_W-1:0]  dbh0;
        logic signed [CPROD_W-1:0]  dbh1;
        t_halves                    h;
    } t_s2;

    typedef struct packed {
        logic [CMAG_W-1:0] dist_aw;
        logic [CMAG_W-1:0] dist_ah;
        logic [CMAG_W-1:0] dist_bw;
        logic [CMAG_W-1:0] dist_bh;
        logic [EXT_W-1:0]  pw_b;
        logic [EXT_W-1:0]  qh_b;
        logic [EXT_W-1:0]  qw_b;
        logic [EXT_W-1:0]  ph_b;
        logic [EXT_W-1:0]  pw_a;
        logic [EXT_W-1:0]  qh_a;
        logic [EXT_W-1:0]  qw_a;
        logic [EXT_W-1:0]  ph_a;
        t_halves           h;
    } t_s3;

    function automatic logic [DOTMAG_W-1:0] dot_mag(input logic signed [DOT_W-1:0] v);
        logic signed [DOT_W-1:0] n;
        n = -v;
        return v[DOT_W-1] ? n[DOTMAG_W-1:0] : v[DOTMAG_W-1:0];
    endfunction

    function automatic logic [CMAG_W-1:0] dist_mag(input logic signed [CSUM_W-1:0] v);
        logic signed [CSUM_W-1:0] n;
        n = -v;
        return v[CSUM_W-1] ? n[CMAG_W-1:0] : v[CMAG_W-1:0];
    endfunction

endpackage

### src/obb_diff.sv
// First stage: centre difference and component products of the two direction vectors.
module obb_diff (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  obb_pkg::t_box  i_a,
    input  obb_pkg::t_box  i_b,
    output logic           o_vld,
    output obb_pkg::t_s1   o_data
);

    logic         r_vld;
    obb_pkg::t_s1 r_data;
    obb_pkg::t_s1 n_data;

    always_comb begin
        n_data     = r_data;
        n_data.dx  = {i_a.cx[obb_pkg::POS_W-1], i_a.cx} - {i_b.cx[obb_pkg::POS_W-1], i_b.cx};
        n_data.dy  = {i_a.cy[obb_pkg::POS_W-1], i_a.cy} - {i_b.cy[obb_pkg::POS_W-1], i_b.cy};
        n_data.pcc = i_a.c * i_b.c;
        n_data.pss = i_a.s * i_b.s;
        n_data.pcs = i_a.c * i_b.s;
        n_data.psc = i_a.s * i_b.c;
        n_data.ac  = i_a.c;
        n_data.as  = i_a.s;
        n_data.bc  = i_b.c;
        n_data.bs  = i_b.s;
        n_data.h   = '{ahw: i_a.hw, ahh: i_a.hh, bhw: i_b.hw, bhh: i_b.hh};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

### src/obb_dot.sv
// Second stage: direction dot magnitudes and centre-distance products on all four axes.
module obb_dot (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  obb_pkg::t_s1   i_data,
    output logic           o_vld,
    output obb_pkg::t_s2   o_data
);

    logic                               r_vld;
    obb_pkg::t_s2                       r_data;
    obb_pkg::t_s2                       n_data;
    logic signed [obb_pkg::DOT_W-1:0]   p_dot;
    logic signed [obb_pkg::DOT_W-1:0]   q_dot;

    always_comb begin
        p_dot = {i_data.pcc[obb_pkg::DPROD_W-1], i_data.pcc}
              + {i_data.pss[obb_pkg::DPROD_W-1], i_data.pss};
        q_dot = {i_data.pcs[obb_pkg::DPROD_W-1], i_data.pcs}
              - {i_data.psc[obb_pkg::DPROD_W-1], i_data.psc};
        n_data      = r_data;
        n_data.pmag = obb_pkg::dot_mag(p_dot);
        n_data.qmag = obb_pkg::dot_mag(q_dot);
        n_data.daw0 = i_data.dx * i_data.ac;
        n_data.daw1 = i_data.dy * i_data.as;
        n_data.dah0 = i_data.dx * i_data.as;
        n_data.dah1 = i_data.dy * i_data.ac;
        n_data.dbw0 = i_data.dx * i_data.bc;
        n_data.dbw1 = i_data.dy * i_data.bs;
        n_data.dbh0 = i_data.dx * i_data.bs;
        n_data.dbh1 = i_data.dy * i_data.bc;
        n_data.h    = i_data.h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

### src/obb_extent.sv
// Third stage: projected distance magnitudes and projected half-extent terms.
module obb_extent (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  obb_pkg::t_s2   i_data,
    output logic           o_vld,
    output obb_pkg::t_s3   o_data
);

    logic                                r_vld;
    obb_pkg::t_s3                        r_data;
    obb_pkg::t_s3                        n_data;
    logic signed [obb_pkg::CSUM_W-1:0]   s_aw;
    logic signed [obb_pkg::CSUM_W-1:0]   s_ah;
    logic signed [obb_pkg::CSUM_W-1:0]   s_bw;
    logic signed [obb_pkg::CSUM_W-1:0]   s_bh;

    always_comb begin
        s_aw = {i_data.daw0[obb_pkg::CPROD_W-1], i_data.daw0}
             + {i_data.daw1[obb_pkg::CPROD_W-1], i_data.daw1};
        s_ah = {i_data.dah0[obb_pkg::CPROD_W-1], i_data.dah0}
             - {i_data.dah1[obb_pkg::CPROD_W-1], i_data.dah1};
        s_bw = {i_data.dbw0[obb_pkg::CPROD_W-1], i_data.dbw0}
             + {i_data.dbw1[obb_pkg::CPROD_W-1], i_data.dbw1};
        s_bh = {i_data.dbh0[obb_pkg::CPROD_W-1], i_data.dbh0}
             - {i_data.dbh1[obb_pkg::CPROD_W-1], i_data.dbh1};
        n_data         = r_data;
        n_data.dist_aw = obb_pkg::dist_mag(s_aw);
        n_data.dist_ah = obb_pkg::dist_mag(s_ah);
        n_data.dist_bw = obb_pkg::dist_mag(s_bw);
        n_data.dist_bh = obb_pkg::dist_mag(s_bh);
        n_data.pw_b    = i_data.pmag * i_data.h.bhw;
        n_data.qh_b    = i_data.qmag * i_data.h.bhh;
        n_data.qw_b    = i_data.qmag * i_data.h.bhw;
        n_data.ph_b    = i_data.pmag * i_data.h.bhh;
        n_data.pw_a    = i_data.pmag * i_data.h.ahw;
        n_data.qh_a    = i_data.qmag * i_data.h.ahh;
        n_data.qw_a    = i_data.qmag * i_data.h.ahw;
        n_data.ph_a    = i_data.pmag * i_data.h.ahh;
        n_data.h       = i_data.h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

### src/obb_decide.sv
// Last stage: per-axis separation compare and the registered overlap result.
module obb_decide (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  obb_pkg::t_s3   i_data,
    output logic           o_vld,
    output logic           o_overlap
);

    localparam int OWN_PAD  = obb_pkg::CMP_W - obb_pkg::HALF_W - obb_pkg::HALF_SHIFT;
    localparam int EXT_PAD  = obb_pkg::CMP_W - obb_pkg::EXT_W;
    localparam int DIST_PAD = obb_pkg::CMP_W - obb_pkg::DIST_W;

    logic                       r_vld;
    logic                       r_overlap;
    logic                       n_overlap;
    logic [obb_pkg::CMP_W-1:0]  d_aw;
    logic [obb_pkg::CMP_W-1:0]  d_ah;
    logic [obb_pkg::CMP_W-1:0]  d_bw;
    logic [obb_pkg::CMP_W-1:0]  d_bh;
    logic [obb_pkg::CMP_W-1:0]  rad_aw;
    logic [obb_pkg::CMP_W-1:0]  rad_ah;
    logic [obb_pkg::CMP_W-1:0]  rad_bw;
    logic [obb_pkg::CMP_W-1:0]  rad_bh;

    always_comb begin
        d_aw = {{DIST_PAD{1'b0}}, i_data.dist_aw, {obb_pkg::DIST_SHIFT{1'b0}}};
        d_ah = {{DIST_PAD{1'b0}}, i_data.dist_ah, {obb_pkg::DIST_SHIFT{1'b0}}};
        d_bw = {{DIST_PAD{1'b0}}, i_data.dist_bw, {obb_pkg::DIST_SHIFT{1'b0}}};
        d_bh = {{DIST_PAD{1'b0}}, i_data.dist_bh, {obb_pkg::DIST_SHIFT{1'b0}}};
        rad_aw = {{OWN_PAD{1'b0}}, i_data.h.ahw, {obb_pkg::HALF_SHIFT{1'b0}}}
               + {{EXT_PAD{1'b0}}, i_data.pw_b} + {{EXT_PAD{1'b0}}, i_data.qh_b};
        rad_ah = {{OWN_PAD{1'b0}}, i_data.h.ahh, {obb_pkg::HALF_SHIFT{1'b0}}}
               + {{EXT_PAD{1'b0}}, i_data.qw_b} + {{EXT_PAD{1'b0}}, i_data.ph_b};
        rad_bw = {{OWN_PAD{1'b0}}, i_data.h.bhw, {obb_pkg::HALF_SHIFT{1'b0}}}
               + {{EXT_PAD{1'b0}}, i_data.pw_a} + {{EXT_PAD{1'b0}}, i_data.qh_a};
        rad_bh = {{OWN_PAD{1'b0}}, i_data.h.bhh, {obb_pkg::HALF_SHIFT{1'b0}}}
               + {{EXT_PAD{1'b0}}, i_data.qw_a} + {{EXT_PAD{1'b0}}, i_data.ph_a};
        n_overlap = !((d_aw >= rad_aw) || (d_ah >= rad_ah) ||
                      (d_bw >= rad_bw) || (d_bh >= rad_bh));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_overlap <= n_overlap;
        end
    end

    assign o_vld     = r_vld;
    assign o_overlap = r_overlap;

endmodule

### src/oriented_box_overlap_test.sv
// Top level of the four-stage oriented box overlap pipeline.
//
// Usage: each input beat carries two oriented boxes (centre, half sizes and
// width direction as cosine and sine); each output beat carries one overlap
// bit, 1 when none of the four box axes separates the pair.
// Input channel: i_valid with the box fields, o_stall back to the sender.
// Output channel: o_valid with o_overlap, i_stall from the receiver.
// A beat moves at a clock edge where valid is high and stall is low.
// Each beat passes four registered stages to its output beat (difference and
// direction products, dot magnitudes and distance products, extent
// products, compare into the output register).
// One pair per cycle while the pipeline is not stalled; each of the first
// three stages holds one multiplier rank, the last holds the adders and compares.
// Reset clears every stage valid bit; the pipeline comes up empty.
// When the receiver stalls, a stage holds only while its successor is full,
// so bubbles close up before o_stall rises; no beat is lost or repeated.
module oriented_box_overlap_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [obb_pkg::POS_W-1:0]    i_a_center_x,
    input  logic signed [obb_pkg::POS_W-1:0]    i_a_center_y,
    input  logic        [obb_pkg::HALF_W-1:0]   i_a_half_width,
    input  logic        [obb_pkg::HALF_W-1:0]   i_a_half_height,
    input  logic signed [obb_pkg::DIR_W-1:0]    i_a_cos,
    input  logic signed [obb_pkg::DIR_W-1:0]    i_a_sin,
    input  logic signed [obb_pkg::POS_W-1:0]    i_b_center_x,
    input  logic signed [obb_pkg::POS_W-1:0]    i_b_center_y,
    input  logic        [obb_pkg::HALF_W-1:0]   i_b_half_width,
    input  logic        [obb_pkg::HALF_W-1:0]   i_b_half_height,
    input  logic signed [obb_pkg::DIR_W-1:0]    i_b_cos,
    input  logic signed [obb_pkg::DIR_W-1:0]    i_b_sin,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_overlap
);

    obb_pkg::t_box  box_a;
    obb_pkg::t_box  box_b;
    obb_pkg::t_s1   s1_data;
    obb_pkg::t_s2   s2_data;
    obb_pkg::t_s3   s3_data;
    logic           s1_vld;
    logic           s2_vld;
    logic           s3_vld;
    logic           s4_vld;
    logic           en1;
    logic           en2;
    logic           en3;
    logic           en4;

    assign box_a = '{cx: i_a_center_x, cy: i_a_center_y, hw: i_a_half_width,
                     hh: i_a_half_height, c: i_a_cos, s: i_a_sin};
    assign box_b = '{cx: i_b_center_x, cy: i_b_center_y, hw: i_b_half_width,
                     hh: i_b_half_height, c: i_b_cos, s: i_b_sin};

    // advance a stage when it is empty or its successor advances
    assign en4     = !s4_vld || !i_stall;
    assign en3     = !s3_vld || en4;
    assign en2     = !s2_vld || en3;
    assign en1     = !s1_vld || en2;
    assign o_stall = !en1;

    obb_diff u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en1),
        .i_vld   (i_valid),
        .i_a     (box_a),
        .i_b     (box_b),
        .o_vld   (s1_vld),
        .o_data  (s1_data)
    );

    obb_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_vld   (s1_vld),
        .i_data  (s1_data),
        .o_vld   (s2_vld),
        .o_data  (s2_data)
    );

    obb_extent u_extent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en3),
        .i_vld   (s2_vld),
        .i_data  (s2_data),
        .o_vld   (s3_vld),
        .o_data  (s3_data)
    );

    obb_decide u_decide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en4),
        .i_vld     (s3_vld),
        .i_data    (s3_data),
        .o_vld     (s4_vld),
        .o_overlap (o_overlap)
    );

    assign o_valid = s4_vld;

endmodule
